// ===== rtl/core/tam_pkg.sv =====
// ----------------------------------------------------------------------------
// tam_pkg
// Shared types and constants of the tile average mosaic unit.
// ----------------------------------------------------------------------------
package tam_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE    = 2'd2;

    localparam int CFG_DW = 11;
    localparam int OUT_DW = 64;

    // control flags that travel with each pixel from front to back
    typedef struct packed {
        logic first;     // first pixel of a tile: restart the sums
        logic tile_end;  // last pixel of a tile: produce the average
        logic last;      // last tile of the image
    } t_op_flags;

endpackage

// ===== rtl/core/tam_queue.sv =====
// ----------------------------------------------------------------------------
// tam_queue
// Small FIFO that decouples pixel classification from accumulation.
// ----------------------------------------------------------------------------
module tam_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end
endmodule

// ===== rtl/core/tam_front.sv =====
// ----------------------------------------------------------------------------
// tam_front
// Holds the configuration and the raster position counters; classifies each
// pixel (tile start, tile end, image end) and works out the clipped tile size.
// ----------------------------------------------------------------------------
module tam_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_TILE   = 64,
    localparam int PCW = $clog2(MAX_WIDTH),
    localparam int PRW = $clog2(MAX_HEIGHT),
    localparam int TW  = $clog2(MAX_TILE + 1),
    localparam int CW  = 2 * TW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [1:0]                i_cfg_index,
    input  logic [tam_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                      i_accept,
    output tam_pkg::t_op_flags        o_flags,
    output logic [PCW-1:0]            o_tile_col,
    output logic [PRW-1:0]            o_tile_row,
    output logic [TW-1:0]             o_tile_w,
    output logic [TW-1:0]             o_tile_h,
    output logic [CW-1:0]             o_count
);
    localparam int TCW = $clog2(MAX_TILE);
    localparam int XW  = (PCW + 1 > 11) ? PCW + 1 : 11;
    localparam int YW  = (PRW + 1 > 11) ? PRW + 1 : 11;
    localparam int ZW  = (TW > 7) ? TW : 7;

    logic [10:0]    r_cfg_w, r_cfg_h;
    logic [6:0]     r_cfg_t;
    logic [PCW-1:0] r_pc, r_tcol;
    logic [PRW-1:0] r_pr, r_trow;
    logic [TCW-1:0] r_cit, r_rit;

    logic [XW-1:0] raw_w, eff_w;
    logic [YW-1:0] raw_h, eff_h;
    logic [ZW-1:0] raw_t, eff_t;
    logic line_end, image_bottom, col_end, row_end;
    logic [TW-1:0] tw, th;

    always_comb begin
        raw_w = XW'(r_cfg_w);
        raw_h = YW'(r_cfg_h);
        raw_t = ZW'(r_cfg_t);
        // zero acts as one, large values clamp to the build maximum
        eff_w = (raw_w == '0) ? XW'(1) : (raw_w > XW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : raw_w;
        eff_h = (raw_h == '0) ? YW'(1) : (raw_h > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : raw_h;
        eff_t = (raw_t == '0) ? ZW'(1) : (raw_t > ZW'(MAX_TILE))   ? ZW'(MAX_TILE)   : raw_t;
        line_end     = (XW'(r_pc) + XW'(1)) >= eff_w;
        image_bottom = (YW'(r_pr) + YW'(1)) >= eff_h;
        col_end      = ((ZW'(r_cit) + ZW'(1)) >= eff_t) || line_end;
        row_end      = ((ZW'(r_rit) + ZW'(1)) >= eff_t) || image_bottom;
        tw           = TW'(r_cit) + TW'(1);
        th           = TW'(r_rit) + TW'(1);
    end

    assign o_flags.first    = (r_cit == '0) && (r_rit == '0);
    assign o_flags.tile_end = col_end && row_end;
    assign o_flags.last     = line_end && image_bottom;
    assign o_tile_col       = r_tcol;
    assign o_tile_row       = r_trow;
    assign o_tile_w         = tw;
    assign o_tile_h         = th;
    assign o_count          = CW'(tw) * CW'(th);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 11'd1024;
            r_cfg_h <= 11'd1024;
            r_cfg_t <= 7'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tam_pkg::REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                tam_pkg::REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                tam_pkg::REG_TILE_SIZE:    r_cfg_t <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_pr   <= '0;
            r_cit  <= '0;
            r_rit  <= '0;
            r_tcol <= '0;
            r_trow <= '0;
        end else if (i_accept) begin
            if (col_end) begin
                r_cit <= '0;
                if (line_end) begin
                    r_pc   <= '0;
                    r_tcol <= '0;
                    if (row_end) begin
                        r_rit <= '0;
                        if (image_bottom) begin
                            r_pr   <= '0;
                            r_trow <= '0;
                        end else begin
                            r_pr   <= r_pr + PRW'(1);
                            r_trow <= r_trow + PRW'(1);
                        end
                    end else begin
                        r_rit <= r_rit + TCW'(1);
                        r_pr  <= r_pr + PRW'(1);
                    end
                end else begin
                    r_pc   <= r_pc + PCW'(1);
                    r_tcol <= r_tcol + PCW'(1);
                end
            end else begin
                r_cit <= r_cit + TCW'(1);
                r_pc  <= r_pc + PCW'(1);
            end
        end
    end
endmodule

// ===== rtl/core/tam_back.sv =====
// ----------------------------------------------------------------------------
// tam_back
// Per tile column sum memory (read-modify-write), an 8-step restoring divider
// for the three colour means, and the result register.
// ----------------------------------------------------------------------------
module tam_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_TILE   = 64,
    localparam int PCW = $clog2(MAX_WIDTH),
    localparam int PRW = $clog2(MAX_HEIGHT),
    localparam int TW  = $clog2(MAX_TILE + 1),
    localparam int CW  = 2 * TW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  tam_pkg::t_op_flags         i_flags,
    input  logic [PCW-1:0]             i_tile_col,
    input  logic [PRW-1:0]             i_tile_row,
    input  logic [TW-1:0]              i_tile_w,
    input  logic [TW-1:0]              i_tile_h,
    input  logic [CW-1:0]              i_count,
    input  logic [23:0]                i_pixel,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [tam_pkg::OUT_DW-1:0] o_data,
    output logic                       o_last
);
    localparam int SW = 8 + CW;

    typedef enum logic [1:0] {S_IDLE, S_RMW, S_DIV, S_HOLD} t_state;

    t_state             r_state;
    logic [3*SW-1:0]    r_mem [MAX_WIDTH];
    logic [3*SW-1:0]    r_rd_data;
    tam_pkg::t_op_flags r_flags;
    logic [PCW-1:0]     r_col;
    logic [PRW-1:0]     r_row;
    logic [TW-1:0]      r_tw, r_th;
    logic [CW-1:0]      r_count;
    logic [23:0]        r_pixel;
    logic [SW-1:0]      r_rem [3];
    logic [7:0]         r_q [3];
    logic [2:0]         r_sat;
    logic [SW-1:0]      r_dsh;
    logic [2:0]         r_step;
    logic               r_out_valid;
    logic [tam_pkg::OUT_DW-1:0] r_out_data;
    logic               r_out_last;

    logic [SW-1:0] n_sum [3];
    logic [SW-1:0] full_div;
    logic          out_free;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;
    assign full_div = SW'(r_count) << 8;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = (r_flags.first ? '0 : r_rd_data[c*SW +: SW]) + SW'(r_pixel[c*8 +: 8]);
        end
    end

    // memory: registered read on pop, write back in the following S_RMW cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[i_tile_col];
        end
        if (r_state == S_RMW) begin
            r_mem[r_col] <= {n_sum[2], n_sum[1], n_sum[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            // in S_HOLD the valid bit is handled by the state arm
            if (r_out_valid && i_ready && r_state != S_HOLD) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_flags <= i_flags;
                        r_col   <= i_tile_col;
                        r_row   <= i_tile_row;
                        r_tw    <= i_tile_w;
                        r_th    <= i_tile_h;
                        r_count <= i_count;
                        r_pixel <= i_pixel;
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    for (int c = 0; c < 3; c++) begin
                        r_rem[c] <= n_sum[c];
                        r_sat[c] <= n_sum[c] >= full_div;
                        r_q[c]   <= '0;
                    end
                    r_dsh   <= SW'(r_count) << 7;
                    r_step  <= '0;
                    r_state <= r_flags.tile_end ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    for (int c = 0; c < 3; c++) begin
                        if (r_rem[c] >= r_dsh) begin
                            r_rem[c] <= r_rem[c] - r_dsh;
                            r_q[c]   <= {r_q[c][6:0], 1'b1};
                        end else begin
                            r_q[c]   <= {r_q[c][6:0], 1'b0};
                        end
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= r_flags.last;
                        r_out_data  <= {6'd0,
                                        r_sat[2] ? 8'hFF : r_q[2],
                                        r_sat[1] ? 8'hFF : r_q[1],
                                        r_sat[0] ? 8'hFF : r_q[0],
                                        7'(r_th), 7'(r_tw), 10'(r_row), 10'(r_col)};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dsh != '0 || r_step != 3'd0))
        else $error("divider started with zero tile area");
    a_rmw_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && !r_flags.tile_end) |=> (r_state == S_IDLE))
        else $error("non-final pixel did not return to idle");
    a_tile_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && r_flags.tile_end) |=> (r_state == S_DIV))
        else $error("tile end did not start the divider");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_RMW))
        else $error("pop without read-modify-write");
`endif
endmodule

// ===== rtl/core/tile_average_mosaic_unit.sv =====
// ----------------------------------------------------------------------------
// tile_average_mosaic_unit
// Block-average mosaic: per tile RGB means of a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; one result leaves when a tile's last pixel
// has been summed. Each pixel passes the back end's S_IDLE and S_RMW states
// (registered read and write back of the tile column sum memory); a finished
// tile adds the shared restoring divider and the S_HOLD state, which loads
// the result register once the output is free. A four-entry queue lets the
// input run ahead in bursts while the back end is busy. Configuration writes
// are taken at any time but belong in idle.
module tile_average_mosaic_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_TILE   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tile_column[9:0], tile_row[19:10], tile_width[26:20], tile_height[33:27],
    // avg_red[41:34], avg_green[49:42], avg_blue[57:50], zeros above
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast   // last_tile
);
    localparam int PCW = $clog2(MAX_WIDTH);
    localparam int PRW = $clog2(MAX_HEIGHT);
    localparam int TW  = $clog2(MAX_TILE + 1);
    localparam int CW  = 2 * TW;
    localparam int QW  = 3 + PCW + PRW + 2 * TW + CW + 24;

    tam_pkg::t_op_flags f_flags, b_flags;
    logic [PCW-1:0] f_col, b_col;
    logic [PRW-1:0] f_row, b_row;
    logic [TW-1:0]  f_tw, f_th, b_tw, b_th;
    logic [CW-1:0]  f_count, b_count;
    logic [23:0]    b_pixel;
    logic [QW-1:0]  q_out;
    logic q_full, q_empty, q_pop, accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    tam_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_TILE(MAX_TILE)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_accept(accept), .o_flags(f_flags), .o_tile_col(f_col), .o_tile_row(f_row),
        .o_tile_w(f_tw), .o_tile_h(f_th), .o_count(f_count)
    );

    tam_queue #(.W(QW), .DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(accept),
        .i_data({f_flags, f_col, f_row, f_tw, f_th, f_count, s_axis_tdata}),
        .o_full(q_full), .i_pop(q_pop), .o_data(q_out), .o_empty(q_empty)
    );

    assign {b_flags, b_col, b_row, b_tw, b_th, b_count, b_pixel} = q_out;

    tam_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_TILE(MAX_TILE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .o_pop(q_pop), .i_flags(b_flags),
        .i_tile_col(b_col), .i_tile_row(b_row), .i_tile_w(b_tw), .i_tile_h(b_th),
        .i_count(b_count), .i_pixel(b_pixel),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule

// ===== dv/tile_average_mosaic_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tile_average_mosaic_unit_tb
// Self-checking bench: streams whole images through the unit under several
// register settings and handshake pressure, predicts each tile average
// in-bench and compares every result item field by field.
// ----------------------------------------------------------------------------
module tile_average_mosaic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    localparam int MAXT = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [9:0] tile_col;
        logic [9:0] tile_row;
        logic [6:0] tile_w;
        logic [6:0] tile_h;
        logic [7:0] avg_r;
        logic [7:0] avg_g;
        logic [7:0] avg_b;
        logic       last;
    } t_tile_avg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = tam_pkg::REG_IMAGE_WIDTH;
    logic [10:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    tile_average_mosaic_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // pixel source and expected tile averages
    logic [23:0] pixel_q[$];
    t_tile_avg   tile_q[$];

    // predictor state
    logic [10:0] cfg_width = 11'd1024;
    logic [10:0] cfg_height = 11'd1024;
    logic [6:0]  cfg_tile = 7'd8;
    int unsigned sum_r[MAXW];
    int unsigned sum_g[MAXW];
    int unsigned sum_b[MAXW];
    int unsigned pcol = 0, prow = 0, cit = 0, rit = 0, tcol = 0, trow = 0;

    int  mode = 0;            // 0 none, 1 sender idle, 2 receiver stall, 3 both
    bit  hold_pause = 0;
    bit  holding = 0;
    bit  px_acc = 0;
    int  cfg_count = 0;
    int  errors = 0;
    int  cycles = 0;
    int  pixels_sent = 0;
    int  tiles_seen = 0;
    int  images_run = 0;

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] mean8(int unsigned s, int unsigned n);
        int unsigned q;
        q = s / n;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic void predict_pixel(logic [23:0] px);
        int unsigned w, h, ts, idx, cnt;
        bit line_end, bottom, col_end, row_end;
        t_tile_avg t;
        w  = clamp_cfg(cfg_width, MAXW);
        h  = clamp_cfg(cfg_height, MAXH);
        ts = clamp_cfg(cfg_tile, MAXT);
        idx = (tcol >= MAXW) ? MAXW - 1 : tcol;
        line_end = pcol + 1 >= w;
        bottom   = prow + 1 >= h;
        col_end  = (cit + 1 >= ts) || line_end;
        row_end  = (rit + 1 >= ts) || bottom;
        if (rit == 0 && cit == 0) begin
            sum_r[idx] = px[7:0];
            sum_g[idx] = px[15:8];
            sum_b[idx] = px[23:16];
        end else begin
            sum_r[idx] += px[7:0];
            sum_g[idx] += px[15:8];
            sum_b[idx] += px[23:16];
        end
        if (col_end && row_end) begin
            cnt = (cit + 1) * (rit + 1);
            t.tile_col = tcol[9:0];
            t.tile_row = trow[9:0];
            t.tile_w = 7'(cit + 1);
            t.tile_h = 7'(rit + 1);
            t.avg_r = mean8(sum_r[idx], cnt);
            t.avg_g = mean8(sum_g[idx], cnt);
            t.avg_b = mean8(sum_b[idx], cnt);
            t.last = line_end && bottom;
            tile_q.push_back(t);
        end
        if (col_end) begin
            cit = 0;
            if (line_end) begin
                pcol = 0;
                tcol = 0;
                if (row_end) begin
                    rit = 0;
                    if (bottom) begin
                        prow = 0;
                        trow = 0;
                    end else begin
                        prow++;
                        trow++;
                    end
                end else begin
                    rit++;
                    prow++;
                end
            end else begin
                pcol++;
                tcol++;
            end
        end else begin
            cit++;
            pcol++;
        end
    endfunction

    // monitor: accepts, config writes and result checks at the rising edge
    always @(posedge i_clk) begin
        t_tile_avg e;
        logic [63:0] d;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tam_pkg::REG_IMAGE_WIDTH:  cfg_width = i_cfg_data;
                    tam_pkg::REG_IMAGE_HEIGHT: cfg_height = i_cfg_data;
                    tam_pkg::REG_TILE_SIZE:    cfg_tile = i_cfg_data[6:0];
                    default: ;
                endcase
                cfg_count++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pixel(s_axis_tdata);
                pixels_sent++;
                px_acc = 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tiles_seen++;
                d = m_axis_tdata;
                if (tile_q.size() == 0) begin
                    $error("unexpected tile item %h", d);
                    errors++;
                end else begin
                    e = tile_q.pop_front();
                    if (d[9:0] !== e.tile_col) begin
                        $error("tile_column exp %0d got %0d", e.tile_col, d[9:0]);
                        errors++;
                    end
                    if (d[19:10] !== e.tile_row) begin
                        $error("tile_row exp %0d got %0d", e.tile_row, d[19:10]);
                        errors++;
                    end
                    if (d[26:20] !== e.tile_w) begin
                        $error("tile_width exp %0d got %0d", e.tile_w, d[26:20]);
                        errors++;
                    end
                    if (d[33:27] !== e.tile_h) begin
                        $error("tile_height exp %0d got %0d", e.tile_h, d[33:27]);
                        errors++;
                    end
                    if (d[41:34] !== e.avg_r) begin
                        $error("avg_red exp %0d got %0d", e.avg_r, d[41:34]);
                        errors++;
                    end
                    if (d[49:42] !== e.avg_g) begin
                        $error("avg_green exp %0d got %0d", e.avg_g, d[49:42]);
                        errors++;
                    end
                    if (d[57:50] !== e.avg_b) begin
                        $error("avg_blue exp %0d got %0d", e.avg_b, d[57:50]);
                        errors++;
                    end
                    if (d[63:58] !== 6'd0) begin
                        $error("tdata pad exp 0 got %0h", d[63:58]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last_tile exp %0d got %0d", e.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // driver: pixels and receiver back-pressure change at the falling edge
    always @(negedge i_clk) begin
        bit send_idle, recv_stall, hold_n;
        send_idle  = (mode == 1 && $urandom_range(99) < 86) ||
                     (mode == 3 && $urandom_range(99) < 12);
        recv_stall = (mode == 2 && $urandom_range(99) < 86) ||
                     (mode == 3 && $urandom_range(99) < 12);
        m_axis_tready <= i_rst_n && !recv_stall;
        hold_n = holding && !px_acc;
        px_acc = 0;
        if (!hold_n && i_rst_n && !hold_pause && !send_idle && pixel_q.size() > 0) begin
            s_axis_tdata  <= pixel_q.pop_front();
            s_axis_tvalid <= 1'b1;
            hold_n = 1;
        end else if (!hold_n) begin
            s_axis_tvalid <= 1'b0;
        end
        holding = hold_n;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        int c0;
        @(negedge i_clk);
        c0 = cfg_count;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (cfg_count == c0);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || holding || tile_q.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // configure, then queue whole images; kind 0 random, 1 white, 2 black
    task automatic run_images(input logic [10:0] w, input logic [10:0] h,
                              input logic [10:0] ts, input int n_img, input int kind);
        int np;
        wait_idle();
        write_reg(tam_pkg::REG_IMAGE_WIDTH, w);
        write_reg(tam_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(tam_pkg::REG_TILE_SIZE, ts);
        np = clamp_cfg(w, MAXW) * clamp_cfg(h, MAXH) * n_img;
        images_run += n_img;
        for (int i = 0; i < np; i++) begin
            case (kind)
                1: pixel_q.push_back(24'hFFFFFF);
                2: pixel_q.push_back(24'h000000);
                default: pixel_q.push_back(24'($urandom));
            endcase
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero registers act as one: single-pixel images
        mode = 0;
        run_images(11'd0, 11'd0, 11'd0, 2, 1);
        run_images(11'd0, 11'd0, 11'd0, 2, 2);
        // clipped edge tiles, all-white and random pixel values
        mode = 1;
        run_images(11'd5, 11'd3, 11'd2, 1, 1);
        mode = 2;
        run_images(11'd5, 11'd3, 11'd2, 1, 0);
        // tile code above 64 clamps; tile field wraps at 7 bits
        mode = 1;
        run_images(11'd3, 11'd2, 11'h7FF, 1, 0);
        mode = 2;
        run_images(11'd2, 11'd2, 11'd128, 1, 0);
        // oversized width clamps to the maximum
        mode = 3;
        run_images(11'h7FF, 11'd1, 11'd64, 1, 0);

        // wait until every tile is out, then pause the source while configuring
        wait_idle();
        hold_pause = 1;
        run_images(11'd6, 11'd4, 11'd3, 1, 0);
        hold_pause = 0;

        while (pixels_sent + pixel_q.size() < 1300) begin
            int w, h, ts, k;
            mode = $urandom_range(3);
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 24);
            h = $urandom_range(1, 12);
            ts = ($urandom_range(7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            k = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
            run_images(11'(w), 11'(h), 11'(ts), $urandom_range(1, 3), k);
            if ($urandom_range(5) == 0) begin
                wait_idle();
                hold_pause = 1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
                hold_pause = 0;
            end
        end
        wait_idle();

        if (tile_q.size() != 0) begin
            $error("%0d tile items never arrived", tile_q.size());
            errors++;
        end
        $display("covered %0d images, %0d pixels, %0d tiles in %0d cycles",
                 images_run, pixels_sent, tiles_seen, cycles);
        $display("settings incl. zero, clamped and wrapped registers; %0d errors", errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tam_pkg.sv
rtl/core/tam_queue.sv
rtl/core/tam_front.sv
rtl/core/tam_back.sv
rtl/core/tile_average_mosaic_unit.sv
dv/tile_average_mosaic_unit_tb.sv
